@@ design/qpd_pkg.sv @@
// Shared types, character codes and helper functions for the quoted-printable decoder.
package qpd_pkg;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_US = 8'h5F;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// What is held between requests
	typedef enum logic [2:0] {
		PEND_NONE = 3'b001,
		PEND_EQ   = 3'b010,
		PEND_BYTE = 3'b100
	} pend_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
	} res_t;

	// Decoded group for one request, plus the state it leaves behind
	typedef struct packed {
		res_t [2:0] slot;
		logic [1:0] cnt;
		pend_t      pend;
		logic [7:0] held;
	} dec_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [7:0] txt_map(input logic hm, input logic [7:0] c);
		return (hm && c == CH_US) ? CH_SP : c;
	endfunction

endpackage

@@ design/qpd_decode.sv @@
// Combinational decode of one request against the held state, giving up to three results.
module qpd_decode (
	input  logic          us_to_sp,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  qpd_pkg::pend_t pend,
	input  logic [7:0]    held,
	output qpd_pkg::dec_t dec
);
	import qpd_pkg::*;

	logic [4:0] hi;
	logic [4:0] lo;
	res_t [2:0] r;
	logic [1:0] n;
	pend_t      np;
	logic [7:0] nh;

	assign hi = hex_nib(held);
	assign lo = hex_nib(in_byte);

	always_comb begin
		r  = '0;
		n  = 2'd0;
		np = PEND_NONE;
		nh = 8'h00;
		unique case (pend)
			PEND_EQ: begin
				np = PEND_BYTE;
				nh = in_byte;
			end
			PEND_BYTE: begin
				if (held == CH_CR && in_byte == CH_LF) begin
					// soft line break: drop
				end else if (held == CH_LF) begin
					if (in_byte == CH_EQ) begin
						np = PEND_EQ;
					end else begin
						r[0] = '{data: txt_map(us_to_sp, in_byte), valid: 1'b1};
						n    = 2'd1;
					end
				end else if (hi[4] && lo[4]) begin
					r[0] = '{data: {hi[3:0], lo[3:0]}, valid: 1'b1};
					n    = 2'd1;
				end else begin
					// not an escape: emit '=' and reprocess both bytes
					r[0] = '{data: CH_EQ, valid: 1'b1};
					n    = 2'd1;
					if (held == CH_EQ) begin
						np = PEND_BYTE;
						nh = in_byte;
					end else begin
						r[1] = '{data: txt_map(us_to_sp, held), valid: 1'b1};
						n    = 2'd2;
						if (in_byte == CH_EQ) begin
							np = PEND_EQ;
						end else begin
							r[2] = '{data: txt_map(us_to_sp, in_byte), valid: 1'b1};
							n    = 2'd3;
						end
					end
				end
			end
			default: begin
				if (in_byte == CH_EQ) begin
					np = PEND_EQ;
				end else begin
					r[0] = '{data: txt_map(us_to_sp, in_byte), valid: 1'b1};
					n    = 2'd1;
				end
			end
		endcase

		if (in_last) begin
			// flush anything still held as literal text
			if (np != PEND_NONE) begin
				unique case (n)
					2'd0:    r[0] = '{data: CH_EQ, valid: 1'b1};
					2'd1:    r[1] = '{data: CH_EQ, valid: 1'b1};
					default: r[2] = '{data: CH_EQ, valid: 1'b1};
				endcase
				n = n + 2'd1;
			end
			if (np == PEND_BYTE) begin
				unique case (n)
					2'd0:    r[0] = '{data: txt_map(us_to_sp, nh), valid: 1'b1};
					2'd1:    r[1] = '{data: txt_map(us_to_sp, nh), valid: 1'b1};
					default: r[2] = '{data: txt_map(us_to_sp, nh), valid: 1'b1};
				endcase
				n = n + 2'd1;
			end
			if (n == 2'd0) begin
				// end marker with no data
				r[0] = '{data: 8'h00, valid: 1'b0};
				n    = 2'd1;
			end
			np = PEND_NONE;
			nh = 8'h00;
		end

		dec.slot = r;
		dec.cnt  = n;
		dec.pend = np;
		dec.held = nh;
	end

endmodule

@@ design/quoted_printable_decoder.sv @@
// Top level of the quoted-printable decoder: input register, decode, result buffer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | in        | in_valid / in_ready   | in_byte, in_last
//  out     | out       | out_valid / out_ready | out_byte, byte_valid, run_last, text_end
//  cfg     | in        | cfg_we                | cfg_wdata (underscore to space)
//
// One request per cycle while each yields at most one result and out_ready is high; otherwise a
// request waits in the input register while the result buffer drains one result per ready cycle.
// A request passes the input register, then is decoded into the result buffer.
// Reset clears held state, the underscore mapping, the input valid flag and the result count; nothing is held after.
// A stalled output holds its result; the input register keeps taking requests as the buffer frees.
module quoted_printable_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       text_end
);
	import qpd_pkg::*;

	logic       us_map_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	pend_t      pend_q;
	logic [7:0] held_q;
	res_t [2:0] res_q;
	logic [1:0] cnt_q;
	logic       end_q;
	logic       adv;
	logic       pop;
	dec_t       dec;

	qpd_decode u_decode (
		.us_to_sp (us_map_q),
		.in_byte  (byte_s1),
		.in_last  (last_s1),
		.pend     (pend_q),
		.held     (held_q),
		.dec      (dec)
	);

	assign pop       = out_valid && out_ready;
	assign adv       = valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready));
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = cnt_q != 2'd0;
	assign out_byte  = res_q[0].data;
	assign byte_valid = res_q[0].valid;
	assign run_last  = cnt_q == 2'd1;
	assign text_end  = (cnt_q == 2'd1) && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_map_q <= 1'b0;
		end else if (cfg_we) begin
			us_map_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= 8'h00;
			cnt_q  <= 2'd0;
			end_q  <= 1'b0;
		end else if (adv) begin
			pend_q <= dec.pend;
			held_q <= dec.held;
			cnt_q  <= dec.cnt;
			end_q  <= last_s1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= dec.slot;
		end else if (pop) begin
			// advance the queue by one result
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

`ifndef SYNTH
	// a data-less result only ever closes the text
	a_marker_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> text_end)
		else $error("marker result without text end");

	// the final byte of a text always releases everything held
	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> pend_q == PEND_NONE && held_q == 8'h00)
		else $error("state held across end of text");

	// the final byte of a text always yields at least one result
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |-> dec.cnt != 2'd0)
		else $error("end of text with no result");
`endif

endmodule
